### sv/lpp_pkg.sv
// Shared types, constants and pattern decode for the line position PID block.
`default_nettype none
package lpp_pkg;

   localparam int INTEGRAL_WIDTH = 16;
   localparam int PATTERN_W      = 7;
   localparam int POS_W          = 3;
   localparam int DELTA_W        = POS_W + 1;
   localparam int GAIN_W         = 8;
   localparam int LIMIT_W        = 7;
   localparam int DRIVE_W        = 8;
   localparam int PROD_P_W       = GAIN_W + POS_W;
   localparam int PROD_I_W       = GAIN_W + INTEGRAL_WIDTH;
   localparam int PROD_D_W       = GAIN_W + DELTA_W;
   localparam int RAW_W          = PROD_I_W + 2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP     = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEGRAL = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV    = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_DRIVE_LIMIT   = 2'd3;

   localparam logic signed [GAIN_W-1:0] GAIN_PROP_RESET     = 8'sd2;
   localparam logic signed [GAIN_W-1:0] GAIN_INTEGRAL_RESET = 8'sd0;
   localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RESET    = 8'sd0;
   localparam logic [LIMIT_W-1:0]       DRIVE_LIMIT_RESET   = 7'd10;

   typedef struct packed {
      logic                    known;
      logic signed [POS_W-1:0] pos;
   } decode_type;

   function automatic decode_type decode_pattern(input logic [PATTERN_W-1:0] pat,
                                                 input logic signed [POS_W-1:0] held);
      decode_type d;
      d.known = 1'b1;
      d.pos   = held;
      case (pat)
         7'd1:         d.pos = 3'sd3;
         7'd2, 7'd3:   d.pos = 3'sd2;
         7'd4, 7'd6:   d.pos = 3'sd1;
         7'd8, 7'd12:  d.pos = 3'sd0;
         7'd16, 7'd24: d.pos = -3'sd1;
         7'd32, 7'd48: d.pos = -3'sd2;
         7'd64, 7'd96: d.pos = -3'sd3;
         default:      d.known = 1'b0;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

### sv/lpp_if.sv
// Request and response channel interfaces for the line position PID block.
`default_nettype none
interface lpp_req_if;
   logic                                valid;
   logic                                ready;
   logic [lpp_pkg::PATTERN_W-1:0]       sensor_pattern;

   modport source (output valid, output sensor_pattern, input ready);
   modport sink   (input valid, input sensor_pattern, output ready);
endinterface

interface lpp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lpp_pkg::DRIVE_W-1:0]  drive;
   logic signed [lpp_pkg::POS_W-1:0]    position;
   logic                                pattern_known;
   logic                                clamped;

   modport source (output valid, output drive, output position, output pattern_known,
                   output clamped, input ready);
   modport sink   (input valid, input drive, input position, input pattern_known,
                   input clamped, output ready);
endinterface
`default_nettype wire

### sv/line_position_pid.sv
// Line position PID controller top level: decode, integrate, multiply, clamp.
// Takes one sensor pattern request per clock, a throughput of one request per cycle,
// unless the response side stalls, and returns one response per request, in order.
// Three register stages sit behind the request port: decode and integral update, the
// three gain multipliers, then the sum and clamp. A request passes the stage 1,
// stage 2 and output registers before its response is valid, and each stage holds
// while the response side stalls. The position and integral state update as each
// request is taken. Gains and the drive limit sit in APB registers at byte addresses
// 0, 4, 8 and 12 and are to be written only while no request is in flight.
`default_nettype none
module line_position_pid (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lpp_req_if.sink                              req_bus,
   lpp_rsp_if.source                            rsp_bus,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [lpp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [lpp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [lpp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   localparam int IW = lpp_pkg::INTEGRAL_WIDTH;
   localparam logic signed [IW:0] IMAX = {2'b00, {(IW-1){1'b1}}};
   localparam logic signed [IW:0] IMIN = {2'b11, {(IW-1){1'b0}}};

   // configuration
   logic signed [lpp_pkg::GAIN_W-1:0]  gain_prop_ff, gain_integral_ff, gain_deriv_ff;
   logic        [lpp_pkg::LIMIT_W-1:0] drive_limit_ff;
   logic                               csr_write;
   logic [lpp_pkg::REG_IDX_W-1:0]      csr_idx;

   // running state
   logic signed [lpp_pkg::POS_W-1:0]   prev_pos_ff;
   logic signed [IW-1:0]               integ_ff;

   // stage 1
   logic                               s1_valid_ff;
   logic                               s1_known_ff;
   logic signed [lpp_pkg::POS_W-1:0]   s1_pos_ff;
   logic signed [IW-1:0]               s1_sum_ff;
   logic signed [lpp_pkg::DELTA_W-1:0] s1_delta_ff;

   // stage 2
   logic                                s2_valid_ff;
   logic                                s2_known_ff;
   logic signed [lpp_pkg::POS_W-1:0]    s2_pos_ff;
   logic signed [lpp_pkg::PROD_P_W-1:0] s2_prod_p_ff;
   logic signed [lpp_pkg::PROD_I_W-1:0] s2_prod_i_ff;
   logic signed [lpp_pkg::PROD_D_W-1:0] s2_prod_d_ff;

   // output stage
   logic                                out_valid_ff;
   logic signed [lpp_pkg::DRIVE_W-1:0]  out_drive_ff;
   logic signed [lpp_pkg::POS_W-1:0]    out_pos_ff;
   logic                                out_known_ff;
   logic                                out_clamped_ff;

   logic out_ready, s2_ready, s1_ready, req_take;

   lpp_pkg::decode_type                 dec_in;
   logic signed [IW:0]                  sum_wide;
   logic signed [IW-1:0]                sum_in;
   logic signed [lpp_pkg::DELTA_W-1:0]  delta_in;

   logic signed [lpp_pkg::PROD_P_W-1:0] prod_p_in;
   logic signed [lpp_pkg::PROD_I_W-1:0] prod_i_in;
   logic signed [lpp_pkg::PROD_D_W-1:0] prod_d_in;

   logic signed [lpp_pkg::RAW_W-1:0]    raw_in, lim_pos, lim_neg;
   logic signed [lpp_pkg::DRIVE_W-1:0]  drive_in;
   logic                                clamped_in;

   // handshake
   assign out_ready     = !out_valid_ff || rsp_bus.ready;
   assign s2_ready      = !s2_valid_ff || out_ready;
   assign s1_ready      = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;
   assign req_take      = req_bus.valid && s1_ready;

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.drive         = out_drive_ff;
   assign rsp_bus.position      = out_pos_ff;
   assign rsp_bus.pattern_known = out_known_ff;
   assign rsp_bus.clamped       = out_clamped_ff;

   // decode and integrate
   always_comb begin
      dec_in   = lpp_pkg::decode_pattern(req_bus.sensor_pattern, prev_pos_ff);
      sum_wide = (IW+1)'(integ_ff) + (IW+1)'(dec_in.pos);
      if (sum_wide > IMAX) begin
         sum_in = IMAX[IW-1:0];
      end else if (sum_wide < IMIN) begin
         sum_in = IMIN[IW-1:0];
      end else begin
         sum_in = sum_wide[IW-1:0];
      end
      delta_in = lpp_pkg::DELTA_W'(dec_in.pos) - lpp_pkg::DELTA_W'(prev_pos_ff);
   end

   // multiply
   assign prod_p_in = gain_prop_ff * s1_pos_ff;
   assign prod_i_in = gain_integral_ff * s1_sum_ff;
   assign prod_d_in = gain_deriv_ff * s1_delta_ff;

   // sum and clamp
   always_comb begin
      raw_in  = lpp_pkg::RAW_W'(s2_prod_p_ff) + lpp_pkg::RAW_W'(s2_prod_i_ff)
              + lpp_pkg::RAW_W'(s2_prod_d_ff);
      lim_pos = {{(lpp_pkg::RAW_W-lpp_pkg::LIMIT_W){1'b0}}, drive_limit_ff};
      lim_neg = -lim_pos;
      if (raw_in > lim_pos) begin
         drive_in   = lim_pos[lpp_pkg::DRIVE_W-1:0];
         clamped_in = 1'b1;
      end else if (raw_in < lim_neg) begin
         drive_in   = lim_neg[lpp_pkg::DRIVE_W-1:0];
         clamped_in = 1'b1;
      end else begin
         drive_in   = raw_in[lpp_pkg::DRIVE_W-1:0];
         clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pos_ff  <= '0;
         integ_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            prev_pos_ff <= dec_in.pos;
            integ_ff    <= sum_in;
         end
         if (s1_ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_known_ff <= dec_in.known;
         s1_pos_ff   <= dec_in.pos;
         s1_sum_ff   <= sum_in;
         s1_delta_ff <= delta_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_known_ff  <= s1_known_ff;
         s2_pos_ff    <= s1_pos_ff;
         s2_prod_p_ff <= prod_p_in;
         s2_prod_i_ff <= prod_i_in;
         s2_prod_d_ff <= prod_d_in;
      end
      if (out_ready && s2_valid_ff) begin
         out_drive_ff   <= drive_in;
         out_pos_ff     <= s2_pos_ff;
         out_known_ff   <= s2_known_ff;
         out_clamped_ff <= clamped_in;
      end
   end

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[lpp_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff     <= lpp_pkg::GAIN_PROP_RESET;
         gain_integral_ff <= lpp_pkg::GAIN_INTEGRAL_RESET;
         gain_deriv_ff    <= lpp_pkg::GAIN_DERIV_RESET;
         drive_limit_ff   <= lpp_pkg::DRIVE_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_idx)
            lpp_pkg::REG_GAIN_PROP: begin
               gain_prop_ff <= csr_pwdata[lpp_pkg::GAIN_W-1:0];
            end
            lpp_pkg::REG_GAIN_INTEGRAL: begin
               gain_integral_ff <= csr_pwdata[lpp_pkg::GAIN_W-1:0];
            end
            lpp_pkg::REG_GAIN_DERIV: begin
               gain_deriv_ff <= csr_pwdata[lpp_pkg::GAIN_W-1:0];
            end
            lpp_pkg::REG_DRIVE_LIMIT: begin
               drive_limit_ff <= csr_pwdata[lpp_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         lpp_pkg::REG_GAIN_PROP: begin
            csr_prdata = {{(lpp_pkg::CSR_DATA_W-lpp_pkg::GAIN_W){1'b0}}, gain_prop_ff};
         end
         lpp_pkg::REG_GAIN_INTEGRAL: begin
            csr_prdata = {{(lpp_pkg::CSR_DATA_W-lpp_pkg::GAIN_W){1'b0}}, gain_integral_ff};
         end
         lpp_pkg::REG_GAIN_DERIV: begin
            csr_prdata = {{(lpp_pkg::CSR_DATA_W-lpp_pkg::GAIN_W){1'b0}}, gain_deriv_ff};
         end
         lpp_pkg::REG_DRIVE_LIMIT: begin
            csr_prdata = {{(lpp_pkg::CSR_DATA_W-lpp_pkg::LIMIT_W){1'b0}}, drive_limit_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

endmodule
`default_nettype wire
